>>> design/ea_extension_word_decoder_core_macros.svh
// Assertion macros for the effective-address extension word decoder.
`ifndef EA_EXTENSION_WORD_DECODER_CORE_MACROS_SVH
`define EA_EXTENSION_WORD_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EWD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ewd_pkg.sv
// Types, codes and helper functions of the extension word decoder.
package ewd_pkg;

    // Opcodes of an input transaction
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_WORD  = 1'b1;

    // Mode field values
    localparam logic [2:0] MODE_PREDEC = 3'd4;
    localparam logic [2:0] MODE_DISP   = 3'd5;
    localparam logic [2:0] MODE_INDEX  = 3'd6;
    localparam logic [2:0] MODE_EXT    = 3'd7;

    // Register field values under mode 7
    localparam logic [2:0] REG_ABS_W   = 3'd0;
    localparam logic [2:0] REG_ABS_L   = 3'd1;
    localparam logic [2:0] REG_PC_DISP = 3'd2;
    localparam logic [2:0] REG_PC_IDX  = 3'd3;
    localparam logic [2:0] REG_IMM     = 3'd4;

    // Operand sizes
    localparam logic [2:0] SZ_BYTE     = 3'd0;
    localparam logic [2:0] SZ_WORD     = 3'd1;
    localparam logic [2:0] SZ_LONG     = 3'd2;
    localparam logic [2:0] SZ_DLONG    = 3'd3;
    localparam logic [2:0] SZ_SINGLE   = 3'd4;
    localparam logic [2:0] SZ_DOUBLE   = 3'd5;
    localparam logic [2:0] SZ_EXTENDED = 3'd6;
    localparam logic [2:0] SZ_PACKED   = 3'd7;

    // Mode classes of a result
    localparam logic [3:0] MC_DN       = 4'd0;
    localparam logic [3:0] MC_DISP     = 4'd5;
    localparam logic [3:0] MC_INDEX    = 4'd6;
    localparam logic [3:0] MC_ABS_W    = 4'd7;
    localparam logic [3:0] MC_ABS_L    = 4'd8;
    localparam logic [3:0] MC_PC_DISP  = 4'd9;
    localparam logic [3:0] MC_PC_INDEX = 4'd10;
    localparam logic [3:0] MC_IMM      = 4'd11;

    // Full-format size codes (base displacement and outer displacement)
    localparam logic [1:0] DSZ_RSVD = 2'd0;
    localparam logic [1:0] DSZ_NULL = 2'd1;
    localparam logic [1:0] DSZ_WORD = 2'd2;

    // I/IS value that is illegal with an active index
    localparam logic [2:0] IIS_ILLEGAL = 3'd4;

    // Largest number of extension words a descriptor can take
    localparam logic [2:0] MAX_WORDS = 3'd6;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  ea_mode;
        logic [2:0]  ea_reg;
        logic [2:0]  operand_size;
        logic [31:0] start_pc;
        logic [15:0] ext_word;
    } ewd_in_t;

    typedef struct packed {
        logic               status;
        logic [3:0]         mode_class;
        logic [3:0]         index_reg;
        logic               index_long;
        logic [1:0]         scale_shift;
        logic               base_suppressed;
        logic               index_suppressed;
        logic [2:0]         indirect_select;
        logic signed [31:0] base_disp;
        logic signed [31:0] outer_disp;
        logic [31:0]        pc_target;
        logic [2:0]         words_used;
    } ewd_out_t;

    function automatic logic [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Extension words taken by an immediate of each operand size
    function automatic logic [2:0] imm_words(input logic [2:0] size);
        logic [2:0] n;
        case (size)
            SZ_BYTE:     n = 3'd1;
            SZ_WORD:     n = 3'd1;
            SZ_LONG:     n = 3'd2;
            SZ_DLONG:    n = 3'd4;
            SZ_SINGLE:   n = 3'd2;
            SZ_DOUBLE:   n = 3'd4;
            SZ_EXTENDED: n = 3'd6;
            SZ_PACKED:   n = 3'd6;
            default:     n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] simple_class(input logic [2:0] mode, input logic [2:0] rg);
        logic [3:0] c;
        if (mode == MODE_DISP) begin
            c = MC_DISP;
        end else begin
            case (rg)
                REG_ABS_W:   c = MC_ABS_W;
                REG_ABS_L:   c = MC_ABS_L;
                REG_PC_DISP: c = MC_PC_DISP;
                default:     c = MC_IMM;
            endcase
        end
        return c;
    endfunction

    // Result of a full-format descriptor once all its words are in
    function automatic ewd_out_t full_result(input logic [15:0] fw, input logic [31:0] bv,
                                             input logic [31:0] pc, input logic [31:0] od,
                                             input logic pcidx);
        ewd_out_t   r;
        logic       is_s;
        logic [2:0] iis;
        r          = '0;
        is_s       = fw[6];
        iis        = fw[2:0];
        r.mode_class = pcidx ? MC_PC_INDEX : MC_INDEX;
        if ((!is_s && iis == IIS_ILLEGAL) || (is_s && iis[2])) begin
            r.status = 1'b1;
        end else begin
            if (!is_s) begin
                r.index_reg   = fw[15:12];
                r.index_long  = fw[11];
                r.scale_shift = fw[10:9];
            end
            r.base_suppressed  = fw[7];
            r.index_suppressed = is_s;
            r.indirect_select  = iis;
            r.base_disp        = bv;
            r.outer_disp       = od;
            if (pcidx) begin
                r.pc_target = fw[7] ? bv : pc + bv;
            end
        end
        return r;
    endfunction

endpackage

>>> design/ea_extension_word_decoder_core.sv
// Effective-address extension word decoder: sequencer, decode and output queue.
// Results are registered; a result that cannot enter the head register waits in the skid register.
// Throughput: one input transaction per cycle while s_ready is high; each word is one pass
//   of field selects, sign extension and one 32-bit add ahead of the result register.
// Result register plus skid register keep s_ready high while one result waits on m_ready.
// Reset (aresetn, synchronous, active low): sequencer idle, queue empty, cpu_is_020 = 1.
module ea_extension_word_decoder_core
    import ewd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,

    input  logic     cfg_wr_en,
    input  logic     cfg_wr_data,

    input  logic     s_valid,
    output logic     s_ready,
    input  ewd_in_t  s_data,

    output logic     m_valid,
    input  logic     m_ready,
    output ewd_out_t m_data
);

`include "ea_extension_word_decoder_core_macros.svh"

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIMPLE,
        PH_FORMAT,
        PH_BD,
        PH_OD
    } phase_t;

    // Sequencer state
    phase_t      phase_reg, phase_next;
    logic [2:0]  words_left_reg, words_left_next;
    logic [2:0]  held_mode_reg, held_mode_next;
    logic [2:0]  held_reg_reg, held_reg_next;
    logic [2:0]  held_size_reg, held_size_next;
    logic [15:0] format_word_reg, format_word_next;
    logic [15:0] high_half_reg, high_half_next;
    logic [31:0] base_value_reg, base_value_next;
    logic [31:0] saved_pc_reg, saved_pc_next;
    logic [2:0]  word_count_reg, word_count_next;
    logic        cpu_is_020_reg;

    // Output queue: out is the head, skid holds a second result
    ewd_out_t    out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    logic        in_fire;
    logic        out_fire;
    logic        emit;
    ewd_out_t    res;

    // Decode temporaries
    logic [15:0] w;
    logic        pcidx;
    logic        is_imm;
    logic [2:0]  k;
    logic [31:0] v;
    logic [31:0] od;
    logic [3:0]  cls;

    assign s_ready  = !skid_valid_reg;
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign out_fire = out_valid_reg && m_ready;

    assign w      = s_data.ext_word;
    assign pcidx  = (held_mode_reg == MODE_EXT) && (held_reg_reg == REG_PC_IDX);
    assign is_imm = (held_mode_reg == MODE_EXT) && (held_reg_reg == REG_IMM);

    // Next state and result for the transaction on the input
    always_comb begin
        phase_next       = phase_reg;
        words_left_next  = words_left_reg;
        held_mode_next   = held_mode_reg;
        held_reg_next    = held_reg_reg;
        held_size_next   = held_size_reg;
        format_word_next = format_word_reg;
        high_half_next   = high_half_reg;
        base_value_next  = base_value_reg;
        saved_pc_next    = saved_pc_reg;
        word_count_next  = word_count_reg;
        emit             = 1'b0;
        res              = '0;
        k                = word_count_reg;
        v                = '0;
        od               = '0;
        cls              = MC_DN;

        if (s_data.opcode == OP_BEGIN) begin
            held_mode_next   = s_data.ea_mode;
            held_reg_next    = s_data.ea_reg;
            held_size_next   = s_data.operand_size;
            saved_pc_next    = s_data.start_pc;
            format_word_next = '0;
            high_half_next   = '0;
            base_value_next  = '0;
            word_count_next  = '0;
            words_left_next  = '0;
            phase_next       = PH_IDLE;
            if (s_data.ea_mode <= MODE_PREDEC) begin
                // register modes need no extension words
                res.mode_class = {1'b0, s_data.ea_mode};
                emit           = 1'b1;
            end else if (s_data.ea_mode == MODE_INDEX ||
                         (s_data.ea_mode == MODE_EXT && s_data.ea_reg == REG_PC_IDX)) begin
                phase_next = PH_FORMAT;
            end else if (s_data.ea_mode == MODE_DISP) begin
                words_left_next = 3'd1;
                phase_next      = PH_SIMPLE;
            end else begin
                case (s_data.ea_reg)
                    REG_ABS_W, REG_PC_DISP: begin
                        words_left_next = 3'd1;
                        phase_next      = PH_SIMPLE;
                    end
                    REG_ABS_L: begin
                        words_left_next = 3'd2;
                        phase_next      = PH_SIMPLE;
                    end
                    REG_IMM: begin
                        words_left_next = imm_words(s_data.operand_size);
                        phase_next      = PH_SIMPLE;
                    end
                    default: begin
                        // mode 7 with an undefined register field
                        res.status = 1'b1;
                        emit       = 1'b1;
                    end
                endcase
            end
        end else begin
            case (phase_reg)
                PH_SIMPLE: begin
                    word_count_next = word_count_reg + 3'd1;
                    if (words_left_reg != '0) begin
                        words_left_next = words_left_reg - 3'd1;
                    end
                    if (!k[0]) begin
                        high_half_next = w;
                    end else if (k == 3'd1) begin
                        base_value_next = {high_half_reg, w};
                    end
                    if (words_left_next == '0) begin
                        cls = simple_class(held_mode_reg, held_reg_reg);
                        if (is_imm && held_size_reg >= SZ_SINGLE) begin
                            v = '0;   // float immediates only consume their words
                        end else if (is_imm && held_size_reg == SZ_DLONG) begin
                            v  = base_value_next;
                            od = {high_half_next, w};
                        end else if (word_count_next == 3'd1) begin
                            v = (is_imm && held_size_reg == SZ_BYTE) ? sx8(w[7:0]) : sx16(w);
                        end else begin
                            v = base_value_next;
                        end
                        res.mode_class = cls;
                        res.base_disp  = v;
                        res.outer_disp = od;
                        if (cls == MC_PC_DISP) begin
                            res.pc_target = saved_pc_reg + v;
                        end
                        emit = 1'b1;
                    end
                end
                PH_FORMAT: begin
                    format_word_next = w;
                    word_count_next  = 3'd1;
                    if (!cpu_is_020_reg || !w[8]) begin
                        // brief format
                        res.mode_class  = pcidx ? MC_PC_INDEX : MC_INDEX;
                        res.index_reg   = w[15:12];
                        res.index_long  = w[11];
                        res.scale_shift = cpu_is_020_reg ? w[10:9] : 2'd0;
                        res.base_disp   = sx8(w[7:0]);
                        if (pcidx) begin
                            res.pc_target = saved_pc_reg + sx8(w[7:0]);
                        end
                        emit = 1'b1;
                    end else if (w[5:4] == DSZ_RSVD) begin
                        res.status     = 1'b1;
                        res.mode_class = pcidx ? MC_PC_INDEX : MC_INDEX;
                        emit           = 1'b1;
                    end else begin
                        base_value_next = '0;
                        if (w[5:4] == DSZ_NULL) begin
                            if (w[1:0] < DSZ_WORD) begin
                                res  = full_result(w, '0, saved_pc_reg, '0, pcidx);
                                emit = 1'b1;
                            end else begin
                                words_left_next = (w[1:0] == DSZ_WORD) ? 3'd1 : 3'd2;
                                phase_next      = PH_OD;
                            end
                        end else begin
                            words_left_next = (w[5:4] == DSZ_WORD) ? 3'd1 : 3'd2;
                            phase_next      = PH_BD;
                        end
                    end
                end
                PH_BD, PH_OD: begin
                    word_count_next = word_count_reg + 3'd1;
                    if (words_left_reg == 3'd2) begin
                        high_half_next  = w;
                        words_left_next = 3'd1;
                    end else begin
                        words_left_next = '0;
                        v = {high_half_reg, w};
                        if (phase_reg == PH_OD) begin
                            if (format_word_reg[1:0] == DSZ_WORD) begin
                                v = sx16(w);
                            end
                            res  = full_result(format_word_reg, base_value_reg,
                                               saved_pc_reg, v, pcidx);
                            emit = 1'b1;
                        end else begin
                            if (format_word_reg[5:4] == DSZ_WORD) begin
                                v = sx16(w);
                            end
                            base_value_next = v;
                            if (format_word_reg[1:0] < DSZ_WORD) begin
                                res  = full_result(format_word_reg, v, saved_pc_reg,
                                                   '0, pcidx);
                                emit = 1'b1;
                            end else begin
                                words_left_next =
                                    (format_word_reg[1:0] == DSZ_WORD) ? 3'd1 : 3'd2;
                                phase_next      = PH_OD;
                            end
                        end
                    end
                end
                default: begin
                    // word with no descriptor open: dropped
                end
            endcase
        end

        if (emit) begin
            res.words_used  = word_count_next;
            phase_next      = PH_IDLE;
            words_left_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            words_left_reg <= '0;
            cpu_is_020_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cpu_is_020_reg <= cfg_wr_data;
            end
            if (in_fire) begin
                phase_reg       <= phase_next;
                words_left_reg  <= words_left_next;
                held_mode_reg   <= held_mode_next;
                held_reg_reg    <= held_reg_next;
                held_size_reg   <= held_size_next;
                format_word_reg <= format_word_next;
                high_half_reg   <= high_half_next;
                base_value_reg  <= base_value_next;
                saved_pc_reg    <= saved_pc_next;
                word_count_reg  <= word_count_next;
            end
            // result queue: skid drains into the head first, keeping order
            if (!out_valid_reg || out_fire) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= in_fire && emit;
                    if (in_fire && emit) begin
                        skid_reg <= res;
                    end
                end else begin
                    out_valid_reg <= in_fire && emit;
                    if (in_fire && emit) begin
                        out_reg <= res;
                    end
                end
            end else if (in_fire && emit) begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    `EWD_ASSERT_IMPL(a_skid_behind_head, skid_valid_reg, out_valid_reg,
                     "skid holds a result while the head is empty")
    `EWD_ASSERT_IMPL(a_idle_no_words, phase_reg == PH_IDLE, words_left_reg == '0,
                     "idle sequencer still counts pending words")
    `EWD_ASSERT_IMPL(a_fail_fields_clear, m_valid && m_data.status,
                     (m_data.index_reg == '0) && (m_data.base_disp == '0) &&
                     (m_data.pc_target == '0),
                     "illegal encoding carries decoded fields")
    `EWD_ASSERT_IMPL(a_words_bound, m_valid, m_data.words_used <= MAX_WORDS,
                     "word count beyond the longest descriptor")
    `EWD_ASSERT_NEXT(a_reg_mode_result,
                     in_fire && (s_data.opcode == OP_BEGIN) && (s_data.ea_mode <= MODE_PREDEC),
                     m_valid, "register mode begin gave no result")

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the effective-address extension word decoder core.
module tb;
    import ewd_pkg::*;

    // Codes the package leaves out but the stimulus and predictor need by name
    localparam logic [2:0] MODE_DN        = 3'd0;
    localparam logic [2:0] REG_FIRST_RSVD = 3'd5;
    localparam logic [1:0] DSZ_LONG       = 2'd3;

    // Sequencer phases of the decode predictor
    typedef enum logic [2:0] {
        DEC_IDLE, DEC_SIMPLE, DEC_FORMAT, DEC_BASE, DEC_OUTER
    } dec_phase_t;

    logic     aclk;
    logic     aresetn;
    logic     cfg_wr_en;
    logic     cfg_wr_data;
    logic     s_valid;
    logic     s_ready;
    ewd_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    ewd_out_t m_data;

    ea_extension_word_decoder_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the decoder's sequencer and the
    // cpu_is_020 register, updated from transactions seen on the ports.
    // ------------------------------------------------------------------
    logic       mdl_cpu020;
    dec_phase_t dec_phase;
    logic [2:0] words_left;
    logic [2:0] held_mode;
    logic [2:0] held_reg;
    logic [2:0] held_size;
    logic [15:0] format_word;
    logic [15:0] high_half;
    logic [31:0] base_value;
    logic [31:0] saved_pc;
    logic [2:0] word_count;

    ewd_out_t decoded_q[$];     // descriptors decoded but not yet seen on m_data

    // Run statistics and error tally
    int err_count;
    int results_checked;
    int illegal_results;
    int brief_count;
    int full_count;
    int items_sent;
    int work_items;             // items of real traffic, ignored noise excluded

    // Idling knobs, in percent per transaction / per cycle
    int  gap_pct;
    int  stall_pct;
    logic cur_cpu020;           // setting the stimulus side believes is active

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the handshake locks up
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Small helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] ext8(input logic [7:0] b);
        logic signed [31:0] s;
        s = {{24{b[7]}}, b};
        return s;
    endfunction

    function automatic logic [31:0] ext16(input logic [15:0] h);
        logic signed [31:0] s;
        s = {{16{h[15]}}, h};
        return s;
    endfunction

    // words an immediate of a given operand size occupies
    function automatic logic [2:0] imm_word_count(input logic [2:0] sz);
        case (sz)
            SZ_BYTE, SZ_WORD:     return 3'd1;
            SZ_LONG, SZ_SINGLE:   return 3'd2;
            SZ_DLONG, SZ_DOUBLE:  return 3'd4;
            default:              return 3'd6;
        endcase
    endfunction

    function automatic logic is_pc_idx();
        return (held_mode == MODE_EXT) && (held_reg == REG_PC_IDX);
    endfunction

    function automatic logic [3:0] indexed_class();
        return is_pc_idx() ? MC_PC_INDEX : MC_INDEX;
    endfunction

    // ------------------------------------------------------------------
    // Decode predictor
    // ------------------------------------------------------------------
    task automatic reset_model;
        mdl_cpu020  = 1'b1;
        dec_phase   = DEC_IDLE;
        words_left  = '0;
        held_mode   = '0;
        held_reg    = '0;
        held_size   = '0;
        format_word = '0;
        high_half   = '0;
        base_value  = '0;
        saved_pc    = '0;
        word_count  = '0;
        decoded_q.delete();
    endtask

    // closes a descriptor: stamps the word count and queues the expectation
    task automatic post_result(input ewd_out_t r);
        r.words_used = word_count;
        decoded_q.push_back(r);
        dec_phase  = DEC_IDLE;
        words_left = '0;
    endtask

    task automatic finish_full(input logic [31:0] od);
        ewd_out_t   r;
        logic       isup;
        logic [2:0] iis;
        r    = '0;
        isup = format_word[6];
        iis  = format_word[2:0];
        r.mode_class = indexed_class();
        // I/IS = 4 with an active index, or any memory-indirect-post form
        // with the index suppressed, is reserved
        if ((!isup && iis == IIS_ILLEGAL) || (isup && iis[2])) begin
            r.status = 1'b1;
        end else begin
            if (!isup) begin
                r.index_reg   = format_word[15:12];
                r.index_long  = format_word[11];
                r.scale_shift = format_word[10:9];
            end
            r.base_suppressed  = format_word[7];
            r.index_suppressed = isup;
            r.indirect_select  = iis;
            r.base_disp        = base_value;
            r.outer_disp       = od;
            if (is_pc_idx()) begin
                r.pc_target = format_word[7] ? base_value : saved_pc + base_value;
            end
        end
        post_result(r);
    endtask

    task automatic enter_outer;
        if (format_word[1:0] < DSZ_WORD) begin
            finish_full('0);
        end else begin
            words_left = (format_word[1:0] == DSZ_WORD) ? 3'd1 : 3'd2;
            dec_phase  = DEC_OUTER;
        end
    endtask

    task automatic start_descriptor(input ewd_in_t it);
        ewd_out_t r;
        held_mode   = it.ea_mode;
        held_reg    = it.ea_reg;
        held_size   = it.operand_size;
        saved_pc    = it.start_pc;
        format_word = '0;
        high_half   = '0;
        base_value  = '0;
        word_count  = '0;
        words_left  = '0;
        dec_phase   = DEC_IDLE;
        r = '0;
        if (held_mode <= MODE_PREDEC) begin
            r.mode_class = {1'b0, held_mode};
            post_result(r);
        end else if (held_mode == MODE_INDEX || is_pc_idx()) begin
            dec_phase = DEC_FORMAT;
        end else begin
            if (held_mode == MODE_DISP) begin
                words_left = 3'd1;
            end else begin
                case (held_reg)
                    REG_ABS_W, REG_PC_DISP: words_left = 3'd1;
                    REG_ABS_L:              words_left = 3'd2;
                    REG_IMM:                words_left = imm_word_count(held_size);
                    default:                words_left = 3'd0;
                endcase
            end
            if (words_left == 3'd0) begin
                // mode 7 with a reserved register: fails at once as class dn
                r.status = 1'b1;
                post_result(r);
            end else begin
                dec_phase = DEC_SIMPLE;
            end
        end
    endtask

    task automatic take_simple_word(input logic [15:0] w);
        ewd_out_t    r;
        logic [2:0]  k;
        logic [31:0] v;
        logic [31:0] od;
        logic        imm;
        k   = word_count;
        imm = (held_mode == MODE_EXT) && (held_reg == REG_IMM);
        v   = '0;
        od  = '0;
        word_count = word_count + 3'd1;
        if (words_left != 3'd0) begin
            words_left = words_left - 3'd1;
        end
        // even words are high halves; the second word completes the first longword
        if (!k[0]) begin
            high_half = w;
        end else if (k == 3'd1) begin
            base_value = {high_half, w};
        end
        if (words_left == 3'd0) begin
            r = '0;
            if (held_mode == MODE_DISP) begin
                r.mode_class = MC_DISP;
            end else begin
                case (held_reg)
                    REG_ABS_W:   r.mode_class = MC_ABS_W;
                    REG_ABS_L:   r.mode_class = MC_ABS_L;
                    REG_PC_DISP: r.mode_class = MC_PC_DISP;
                    default:     r.mode_class = MC_IMM;
                endcase
            end
            if (imm && held_size >= SZ_SINGLE) begin
                v = '0;                         // float immediates only skip words
            end else if (imm && held_size == SZ_DLONG) begin
                v  = base_value;
                od = {high_half, w};
            end else if (word_count == 3'd1) begin
                v = (imm && held_size == SZ_BYTE) ? ext8(w[7:0]) : ext16(w);
            end else begin
                v = base_value;
            end
            r.base_disp  = v;
            r.outer_disp = od;
            if (r.mode_class == MC_PC_DISP) begin
                r.pc_target = saved_pc + v;
            end
            post_result(r);
        end
    endtask

    task automatic take_format_word(input logic [15:0] w);
        ewd_out_t r;
        format_word  = w;
        word_count   = 3'd1;
        r            = '0;
        r.mode_class = indexed_class();
        if (!mdl_cpu020 || !w[8]) begin
            // brief format: 8-bit displacement, pc target skips the index
            brief_count++;
            r.index_reg   = w[15:12];
            r.index_long  = w[11];
            r.scale_shift = mdl_cpu020 ? w[10:9] : 2'd0;
            r.base_disp   = ext8(w[7:0]);
            if (is_pc_idx()) begin
                r.pc_target = saved_pc + ext8(w[7:0]);
            end
            post_result(r);
        end else begin
            full_count++;
            if (w[5:4] == DSZ_RSVD) begin
                r.status = 1'b1;
                post_result(r);
            end else begin
                base_value = '0;
                if (w[5:4] == DSZ_NULL) begin
                    enter_outer();
                end else begin
                    words_left = (w[5:4] == DSZ_WORD) ? 3'd1 : 3'd2;
                    dec_phase  = DEC_BASE;
                end
            end
        end
    endtask

    task automatic take_disp_word(input logic [15:0] w, input logic outer);
        logic [31:0] v;
        word_count = word_count + 3'd1;
        if (words_left == 3'd2) begin
            high_half  = w;
            words_left = 3'd1;
        end else begin
            words_left = '0;
            v = {high_half, w};
            if (outer) begin
                if (format_word[1:0] == DSZ_WORD) begin
                    v = ext16(w);
                end
                finish_full(v);
            end else begin
                if (format_word[5:4] == DSZ_WORD) begin
                    v = ext16(w);
                end
                base_value = v;
                enter_outer();
            end
        end
    endtask

    task automatic decode_item(input ewd_in_t it);
        if (it.opcode == OP_BEGIN) begin
            start_descriptor(it);
        end else begin
            case (dec_phase)
                DEC_SIMPLE: take_simple_word(it.ext_word);
                DEC_FORMAT: take_format_word(it.ext_word);
                DEC_BASE:   take_disp_word(it.ext_word, 1'b0);
                DEC_OUTER:  take_disp_word(it.ext_word, 1'b1);
                default:    ;                   // stray word while idle
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 40) begin
            $display("ERROR @%0t %s: got %h, expected %h", $time, what, got, want);
        end
    endtask

    task automatic check_result(input ewd_out_t got);
        ewd_out_t want;
        results_checked++;
        if (decoded_q.size() == 0) begin
            report_mismatch("result with no descriptor pending", got.mode_class, '0);
        end else begin
            want = decoded_q.pop_front();
            if (want.status) illegal_results++;
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.mode_class !== want.mode_class)
                report_mismatch("mode_class", got.mode_class, want.mode_class);
            if (got.index_reg !== want.index_reg)
                report_mismatch("index_reg", got.index_reg, want.index_reg);
            if (got.index_long !== want.index_long)
                report_mismatch("index_long", got.index_long, want.index_long);
            if (got.scale_shift !== want.scale_shift)
                report_mismatch("scale_shift", got.scale_shift, want.scale_shift);
            if (got.base_suppressed !== want.base_suppressed)
                report_mismatch("base_suppressed", got.base_suppressed, want.base_suppressed);
            if (got.index_suppressed !== want.index_suppressed)
                report_mismatch("index_suppressed", got.index_suppressed,
                                want.index_suppressed);
            if (got.indirect_select !== want.indirect_select)
                report_mismatch("indirect_select", got.indirect_select, want.indirect_select);
            if (got.base_disp !== want.base_disp)
                report_mismatch("base_disp", got.base_disp, want.base_disp);
            if (got.outer_disp !== want.outer_disp)
                report_mismatch("outer_disp", got.outer_disp, want.outer_disp);
            if (got.pc_target !== want.pc_target)
                report_mismatch("pc_target", got.pc_target, want.pc_target);
            if (got.words_used !== want.words_used)
                report_mismatch("words_used", got.words_used, want.words_used);
        end
    endtask

    // Port monitor: everything is sampled on the rising edge, and within one
    // edge the input transaction is predicted before the output is checked,
    // so the order of processes inside the time step does not matter.
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
        end else begin
            if (cfg_wr_en) begin
                mdl_cpu020 = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                decode_item(s_data);
            end
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
        end
    end

    // Result-side backpressure: random stall bursts that hold m_ready low
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic ewd_in_t rand_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(ewd_in_t)-1:0];
    endfunction

    // begin transaction; unused fields stay random
    function automatic ewd_in_t begin_item(input logic [2:0] md, input logic [2:0] rg,
                                           input logic [2:0] sz, input logic [31:0] pc);
        ewd_in_t it;
        it = rand_item();
        it.opcode       = OP_BEGIN;
        it.ea_mode      = md;
        it.ea_reg       = rg;
        it.operand_size = sz;
        it.start_pc     = pc;
        return it;
    endfunction

    function automatic ewd_in_t word_item(input logic [15:0] w);
        ewd_in_t it;
        it = rand_item();
        it.opcode   = OP_WORD;
        it.ext_word = w;
        return it;
    endfunction

    // extension word biased toward the sign and range extremes
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h8000;
            3:       return 16'h7fff;
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    // Entered and left on a falling edge. Valid is held across back-to-back
    // transactions and only dropped for a gap burst.
    task automatic send_item(input ewd_in_t it);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Idle the input and let every pending result come out, then give the
    // result register some slack.
    task automatic wait_drained;
        s_valid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cpu_mode(input logic v);
        wait_drained();
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
        cur_cpu020 = v;
    endtask

    // One descriptor of random traffic: mostly well formed with random
    // content, a few truncated (abandoned by the next begin) and a few pure noise.
    task automatic gen_descriptor;
        int          pick;
        int          n;
        logic [2:0]  md;
        logic [2:0]  rg;
        logic [2:0]  sz;
        logic [15:0] fw;
        logic [31:0] pc;
        logic [15:0] words[$];
        pick = $urandom_range(0, 99);
        md   = 3'($urandom_range(0, 7));
        rg   = 3'($urandom_range(0, 7));
        sz   = 3'($urandom_range(0, 7));
        pc   = ($urandom_range(0, 7) == 0) ? (32'hffff_ff00 | $urandom_range(0, 255))
                                           : $urandom;
        if (pick < 6) begin
            send_item(rand_item());            // noise, may well be ignored
        end else begin
            // weight toward the indexed modes, where the deep sequences are
            if (pick < 26) begin
                md = MODE_INDEX;
            end else if (pick < 40) begin
                md = MODE_EXT;
                rg = REG_PC_IDX;
            end else if (pick < 54) begin
                md = MODE_EXT;
                rg = REG_IMM;
            end
            if (md == MODE_INDEX || (md == MODE_EXT && rg == REG_PC_IDX)) begin
                fw = 16'($urandom_range(0, 16'hffff));
                words.push_back(fw);
                n = 0;
                if (cur_cpu020 && fw[8] && fw[5:4] != DSZ_RSVD) begin
                    if (fw[5:4] == DSZ_WORD) n = 1;
                    if (fw[5:4] == DSZ_LONG) n = 2;
                    if (fw[1:0] == DSZ_WORD) n = n + 1;
                    if (fw[1:0] == DSZ_LONG) n = n + 2;
                end
            end else if (md == MODE_DISP) begin
                n = 1;
            end else if (md == MODE_EXT) begin
                case (rg)
                    REG_ABS_W, REG_PC_DISP: n = 1;
                    REG_ABS_L:              n = 2;
                    REG_IMM:                n = imm_word_count(sz);
                    default:                n = 0;
                endcase
            end else begin
                n = 0;
            end
            repeat (n) words.push_back(rand_word());
            n = words.size();
            if (n > 0 && $urandom_range(0, 99) < 6) begin
                n = $urandom_range(0, n - 1);  // cut short
            end
            send_item(begin_item(md, rg, sz, pc));
            for (int i = 0; i < n; i++) begin
                send_item(word_item(words[i]));
            end
            work_items += n + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register modes, displacement, absolute, pc displacement, reserved
    // register, stray word, byte immediate and an abandoned descriptor.
    task automatic test_plain_modes;
        logic [2:0] md;
        write_cpu_mode(1'b1);
        gap_pct   = 15;
        stall_pct = 15;
        for (int m = 0; m <= MODE_PREDEC; m++) begin
            md = m[2:0];
            send_item(begin_item(md, md[0] ? 3'd7 : 3'd0, 3'($urandom_range(0, 7)),
                                 $urandom));
        end
        send_item(begin_item(MODE_DISP, 3'd7, SZ_BYTE, 32'h0000_0000));
        send_item(word_item(16'h8000));
        send_item(begin_item(MODE_EXT, REG_ABS_L, SZ_LONG, 32'hffff_ffff));
        send_item(word_item(16'hffff));
        send_item(word_item(16'h0000));
        // pc displacement that wraps past the top of the address space
        send_item(begin_item(MODE_EXT, REG_PC_DISP, SZ_WORD, 32'hffff_fffe));
        send_item(word_item(16'h7fff));
        send_item(begin_item(MODE_EXT, REG_FIRST_RSVD, SZ_WORD, $urandom));
        send_item(word_item(16'hffff));        // no descriptor open: dropped
        send_item(begin_item(MODE_EXT, REG_IMM, SZ_BYTE, $urandom));
        send_item(word_item(16'h0080));
        // begin while busy drops the absolute-long in flight
        send_item(begin_item(MODE_EXT, REG_ABS_L, SZ_LONG, $urandom));
        send_item(word_item(16'h1234));
        send_item(begin_item(MODE_DN, 3'd0, SZ_BYTE, $urandom));
        wait_drained();
    endtask

    // Brief and full index formats with the 68020 extensions on.
    task automatic test_index_formats;
        gap_pct   = 15;
        stall_pct = 15;
        // full format, reserved base displacement size
        send_item(begin_item(MODE_INDEX, 3'd0, SZ_BYTE, $urandom));
        send_item(word_item(16'h0100));
        // pc indexed, base suppressed, long base and long outer displacement
        send_item(begin_item(MODE_EXT, REG_PC_IDX, SZ_BYTE, 32'h8000_0000));
        send_item(word_item(16'hffb3));
        send_item(word_item(16'hffff));
        send_item(word_item(16'hffff));
        send_item(word_item(16'h8000));
        send_item(word_item(16'h0000));
        // active index with I/IS = 4 is illegal
        send_item(begin_item(MODE_INDEX, 3'd7, SZ_BYTE, $urandom));
        send_item(word_item(16'h0114));
        // brief pc indexed, negative displacement wraps below zero
        send_item(begin_item(MODE_EXT, REG_PC_IDX, SZ_BYTE, 32'h0000_0000));
        send_item(word_item(16'h7e80));
        wait_drained();
    endtask

    // With cpu_is_020 clear, bit 8 is ignored and the scale reads as zero.
    task automatic test_brief_without_020;
        write_cpu_mode(1'b0);
        send_item(begin_item(MODE_INDEX, 3'd3, SZ_BYTE, $urandom));
        send_item(word_item(16'hffff));
        wait_drained();
    endtask

    task automatic test_random_traffic(input logic cpu, input int gap, input int stall,
                                       input int n_items);
        int start;
        write_cpu_mode(cpu);
        gap_pct   = gap;
        stall_pct = stall;
        start     = work_items;
        while (work_items - start < n_items) begin
            gen_descriptor();
        end
        // a plain register descriptor closes anything left half done
        send_item(begin_item(MODE_DN, 3'd0, SZ_BYTE, $urandom));
        wait_drained();
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        gap_pct     = 0;
        stall_pct   = 0;
        cur_cpu020  = 1'b1;
        err_count       = 0;
        results_checked = 0;
        illegal_results = 0;
        brief_count     = 0;
        full_count      = 0;
        items_sent      = 0;
        work_items      = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_plain_modes();
        test_index_formats();
        test_brief_without_020();
        test_random_traffic(1'b1, 20, 20, 350);
        test_random_traffic(1'b0,  0, 30, 250);
        test_random_traffic(1'b1, 30,  0, 350);
        // closing stretch runs with no idling on either side
        test_random_traffic(1'b1,  0,  0, 250);

        $display("Sent %0d transactions, checked %0d results (%0d illegal encodings).",
                 items_sent, results_checked, illegal_results);
        $display("Index words: %0d brief, %0d full format; cpu_is_020 exercised at 0 and 1.",
                 brief_count, full_count);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> ea_extension_word_decoder_core.f
+incdir+design
design/ewd_pkg.sv
design/ea_extension_word_decoder_core.sv
tb/sv/tb.sv
